@@ hw/rtl/gmuf_pkg.sv @@
// shared types, constants and codes for the grid maze union-find block
package gmuf_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  localparam int DIM_W    = 6;
  localparam int COORD_W  = 5;
  localparam int COUNT_W  = 10;
  localparam int TARGET_W = 2 * DIM_W;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register index taken from the word address
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam logic [DIM_W-1:0] RST_GRID_ROWS = DIM_W'(32);
  localparam logic [DIM_W-1:0] RST_GRID_COLS = DIM_W'(32);

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SAME     = 2'd1,
    ST_OFF_GRID = 2'd2,
    ST_COMPLETE = 2'd3
  } status_t;

  // clamped grid size and spanning tree edge target
  typedef struct packed {
    logic [DIM_W-1:0]    rows;
    logic [DIM_W-1:0]    cols;
    logic [TARGET_W-1:0] target;
  } grid_cfg_t;

endpackage

@@ hw/rtl/grid_maze_union_find.sv @@
// path: an off-grid or complete-tree edge goes from accept via S_CHECK and S_DONE to the
// output register, any other via S_CHECK, S_WALK_A, S_WALK_B (link walks) and S_DONE
// throughput: one edge at a time, the next accepted once the current one reaches
// the output register; the single read port of the parent memory sets the walk rate
// reset: rst_n clears control state, then a sweep over all MAX_ROWS*MAX_COLS entries
// (1024 by default) rewrites every parent entry with its own index while in_stall is high
module grid_maze_union_find #(
  parameter int MAX_ROWS = gmuf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmuf_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gmuf_pkg::COORD_W-1:0]  in_cell_row,
  input  logic [gmuf_pkg::COORD_W-1:0]  in_cell_col,
  input  logic                          in_toward_down,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_edge_status,
  output logic [gmuf_pkg::COUNT_W-1:0]  out_accepted_count,
  output logic                          out_tree_complete,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gmuf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [gmuf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [gmuf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  gmuf_pkg::grid_cfg_t grid_cfg;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_rdata;

  gmuf_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .grid_cfg    (grid_cfg)
  );

  gmuf_parent_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gmuf_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .grid_cfg           (grid_cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_row        (in_cell_row),
    .in_cell_col        (in_cell_col),
    .in_toward_down     (in_toward_down),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_edge_status    (out_edge_status),
    .out_accepted_count (out_accepted_count),
    .out_tree_complete  (out_tree_complete),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

endmodule

@@ hw/rtl/gmuf_parent_mem.sv @@
// cluster parent memory, one write port and one registered read port
module gmuf_parent_mem #(
  parameter int DEPTH = gmuf_pkg::DEF_MAX_ROWS * gmuf_pkg::DEF_MAX_COLS,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/gmuf_cfg.sv @@
// configuration registers with clamping and tree target
module gmuf_cfg #(
  parameter int MAX_ROWS = gmuf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmuf_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gmuf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [gmuf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [gmuf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output gmuf_pkg::grid_cfg_t           grid_cfg
);

  logic [gmuf_pkg::DIM_W-1:0] rows_r;
  logic [gmuf_pkg::DIM_W-1:0] cols_r;
  logic [gmuf_pkg::DIM_W-1:0] rows_cl;
  logic [gmuf_pkg::DIM_W-1:0] cols_cl;
  logic                       wr_en;
  gmuf_pkg::grid_cfg_t        grid_cfg_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gmuf_pkg::RST_GRID_ROWS;
      cols_r <= gmuf_pkg::RST_GRID_COLS;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        gmuf_pkg::REG_GRID_ROWS: rows_r <= cfg_pwdata[gmuf_pkg::DIM_W-1:0];
        gmuf_pkg::REG_GRID_COLS: cols_r <= cfg_pwdata[gmuf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      gmuf_pkg::REG_GRID_ROWS:
        cfg_prdata = {{(gmuf_pkg::CFG_DW-gmuf_pkg::DIM_W){1'b0}}, rows_r};
      gmuf_pkg::REG_GRID_COLS:
        cfg_prdata = {{(gmuf_pkg::CFG_DW-gmuf_pkg::DIM_W){1'b0}}, cols_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (rows_r == '0)            rows_cl = gmuf_pkg::DIM_W'(1);
    else if (int'(rows_r) > MAX_ROWS)     rows_cl = gmuf_pkg::DIM_W'(MAX_ROWS);
    else                                  rows_cl = rows_r;
    priority if (cols_r == '0)            cols_cl = gmuf_pkg::DIM_W'(1);
    else if (int'(cols_r) > MAX_COLS)     cols_cl = gmuf_pkg::DIM_W'(MAX_COLS);
    else                                  cols_cl = cols_r;
  end

  always_ff @(posedge clk) begin
    grid_cfg_r.rows   <= rows_cl;
    grid_cfg_r.cols   <= cols_cl;
    grid_cfg_r.target <= gmuf_pkg::TARGET_W'(
                           {{gmuf_pkg::DIM_W{1'b0}}, rows_cl} *
                           {{gmuf_pkg::DIM_W{1'b0}}, cols_cl}) - gmuf_pkg::TARGET_W'(1);
  end

  assign grid_cfg = grid_cfg_r;

endmodule

@@ hw/rtl/gmuf_ctrl.sv @@
// sequencer: memory clear sweep, root walks, link write-back and result register
module gmuf_ctrl #(
  parameter int MAX_ROWS = gmuf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmuf_pkg::DEF_MAX_COLS,
  parameter int AW       = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gmuf_pkg::grid_cfg_t            grid_cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gmuf_pkg::COORD_W-1:0]   in_cell_row,
  input  logic [gmuf_pkg::COORD_W-1:0]   in_cell_col,
  input  logic                           in_toward_down,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_edge_status,
  output logic [gmuf_pkg::COUNT_W-1:0]   out_accepted_count,
  output logic                           out_tree_complete,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [AW-1:0]                  mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [AW-1:0]                  mem_rdata
);

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam logic [AW-1:0] LAST_IDX = AW'(CELL_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK_A,
    S_WALK_B,
    S_DONE
  } state_t;

  state_t                           state_r;
  logic [AW-1:0]                    clr_idx_r;
  logic [gmuf_pkg::COORD_W-1:0]     row_r;
  logic [gmuf_pkg::COORD_W-1:0]     col_r;
  logic                             down_r;
  logic [AW-1:0]                    idx_a_r;
  logic [AW-1:0]                    idx_b_r;
  logic [AW-1:0]                    cur_r;
  logic [AW-1:0]                    root_a_r;
  logic [gmuf_pkg::COUNT_W-1:0]     edges_taken_r;
  gmuf_pkg::status_t                status_r;
  logic                             out_valid_r;
  gmuf_pkg::status_t                out_status_r;
  logic [gmuf_pkg::COUNT_W-1:0]     out_count_r;
  logic                             out_complete_r;

  logic                             in_take;
  logic                             out_free;
  logic                             at_root;
  logic [gmuf_pkg::DIM_W-1:0]       row2;
  logic [gmuf_pkg::DIM_W-1:0]       col2;
  logic                             off_grid;
  logic                             is_complete;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign at_root  = (mem_rdata == cur_r);

  assign row2 = {1'b0, row_r} + gmuf_pkg::DIM_W'(down_r);
  assign col2 = {1'b0, col_r} + gmuf_pkg::DIM_W'(!down_r);
  assign off_grid = ({1'b0, row_r} >= grid_cfg.rows) | ({1'b0, col_r} >= grid_cfg.cols) |
                    (row2 >= grid_cfg.rows) | (col2 >= grid_cfg.cols);
  assign is_complete = {{(gmuf_pkg::TARGET_W-gmuf_pkg::COUNT_W){1'b0}}, edges_taken_r}
                       >= grid_cfg.target;

  // read address follows the walk so each cycle checks one link
  always_comb begin
    unique case (state_r)
      S_CHECK:  mem_raddr = idx_a_r;
      S_WALK_A: mem_raddr = at_root ? idx_b_r : mem_rdata;
      S_WALK_B: mem_raddr = mem_rdata;
      default:  mem_raddr = cur_r;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = root_a_r;
    mem_wdata = cur_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = clr_idx_r;
      end
      S_WALK_B: begin
        mem_we = at_root & (cur_r != root_a_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      edges_taken_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // in S_DONE the result register is either loaded or held below
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            row_r   <= in_cell_row;
            col_r   <= in_cell_col;
            down_r  <= in_toward_down;
            idx_a_r <= AW'(int'(in_cell_row) * MAX_COLS + int'(in_cell_col));
            idx_b_r <= AW'((int'(in_cell_row) + int'(in_toward_down)) * MAX_COLS +
                           int'(in_cell_col) + int'(!in_toward_down));
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          cur_r <= idx_a_r;
          priority if (off_grid) begin
            status_r <= gmuf_pkg::ST_OFF_GRID;
            state_r  <= S_DONE;
          end else if (is_complete) begin
            status_r <= gmuf_pkg::ST_COMPLETE;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_WALK_A;
          end
        end
        S_WALK_A: begin
          if (at_root) begin
            root_a_r <= cur_r;
            cur_r    <= idx_b_r;
            state_r  <= S_WALK_B;
          end else begin
            cur_r <= mem_rdata;
          end
        end
        S_WALK_B: begin
          if (at_root) begin
            if (cur_r != root_a_r) begin
              status_r <= gmuf_pkg::ST_ACCEPTED;
              if (edges_taken_r != gmuf_pkg::COUNT_MAX) begin
                edges_taken_r <= edges_taken_r + gmuf_pkg::COUNT_W'(1);
              end
            end else begin
              status_r <= gmuf_pkg::ST_SAME;
            end
            state_r <= S_DONE;
          end else begin
            cur_r <= mem_rdata;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= status_r;
            out_count_r    <= edges_taken_r;
            out_complete_r <= is_complete;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_status    = out_status_r;
  assign out_accepted_count = out_count_r;
  assign out_tree_complete  = out_complete_r;

endmodule

@@ hw/rtl/gmuf_checker.sv @@
// port-level checks for the grid maze union-find block, bound to the top level
module gmuf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_edge_status,
  input logic [gmuf_pkg::COUNT_W-1:0]  out_accepted_count,
  input logic                          out_tree_complete
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_edge_status) &&
      $stable(out_accepted_count) && $stable(out_tree_complete))
    else $error("stalled result changed");

  // one edge in flight: the cycle after an input transaction the block stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second edge taken while one is in flight");

  // an edge refused for completeness comes with the complete flag
  a_complete_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_status == gmuf_pkg::ST_COMPLETE |-> out_tree_complete)
    else $error("complete status without tree_complete");

  // an accepted edge leaves a nonzero count
  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_status == gmuf_pkg::ST_ACCEPTED |-> out_accepted_count != '0)
    else $error("accepted edge with zero count");

endmodule

bind grid_maze_union_find gmuf_checker u_gmuf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_edge_status    (out_edge_status),
  .out_accepted_count (out_accepted_count),
  .out_tree_complete  (out_tree_complete)
);
